### rtl/sawc8_pkg.sv
// ----------------------------------------------------------------------------
// sawc8_pkg
// Shared types, codes and crc-8 helpers for the stop-and-wait link endpoint.
// ----------------------------------------------------------------------------
package sawc8_pkg;

  localparam int FRAME_W   = 19;
  localparam int BODY_W    = 11;
  localparam int CRC_W     = 8;
  localparam int BYTE_W    = 8;

  // crc-8 polynomial x^8+x^2+x+1 without the top bit
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;

  // frame fields
  localparam logic [1:0] TYPE_CMD  = 2'b00;
  localparam logic [1:0] TYPE_DATA = 2'b01;
  localparam logic [1:0] TYPE_CTRL = 2'b10;
  localparam logic [1:0] TYPE_ACK  = 2'b11;

  localparam logic [BYTE_W-1:0] PAY_START = 8'h00;
  localparam logic [BYTE_W-1:0] PAY_STOP  = 8'h3F;
  localparam logic [BYTE_W-1:0] PAY_ACK   = 8'h41;

  // operation codes of an input word
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef enum logic [3:0] {
    EV_START    = 4'd0,
    EV_STOP     = 4'd1,
    EV_CONTROL  = 4'd2,
    EV_DUP      = 4'd3,
    EV_REJECTED = 4'd4,
    EV_SENT     = 4'd5,
    EV_ACKED    = 4'd6,
    EV_BAD_ACK  = 4'd7,
    EV_TIMEOUT  = 4'd8,
    EV_BUSY     = 4'd9
  } evt_t;

  // one result word
  typedef struct packed {
    logic               tx_valid;
    logic [FRAME_W-1:0] tx_frame;
    evt_t               event_res;
    logic [1:0]         angle_code;
    logic [5:0]         sample_count;
    logic               awaiting_ack;
  } res_t;

  // crc over an 11-bit frame body, msb first, init zero
  function automatic logic [CRC_W-1:0] crc8_body(input logic [BODY_W-1:0] bits);
    logic [CRC_W-1:0] crc;
    logic             inv;
    crc = '0;
    for (int i = BODY_W - 1; i >= 0; i--) begin
      inv = bits[i] ^ crc[CRC_W-1];
      crc = {crc[CRC_W-2:0], 1'b0} ^ (inv ? CRC_POLY : '0);
    end
    return crc;
  endfunction

  // residue over a whole frame, zero when the frame checks
  function automatic logic [CRC_W-1:0] crc8_frame(input logic [FRAME_W-1:0] bits);
    logic [CRC_W-1:0] crc;
    logic             inv;
    crc = '0;
    for (int i = FRAME_W - 1; i >= 0; i--) begin
      inv = bits[i] ^ crc[CRC_W-1];
      crc = {crc[CRC_W-2:0], 1'b0} ^ (inv ? CRC_POLY : '0);
    end
    return crc;
  endfunction

  // body plus its crc
  function automatic logic [FRAME_W-1:0] make_frame(input logic [BODY_W-1:0] body);
    return {body, crc8_body(body)};
  endfunction

endpackage

### rtl/sawc8_engine.sv
// ----------------------------------------------------------------------------
// sawc8_engine
// Protocol state and per-word decision logic: classifies received frames,
// builds ack and data frames and updates the sequence bits on each accepted word.
// ----------------------------------------------------------------------------
module sawc8_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [1:0]                   op,
  input  logic [sawc8_pkg::FRAME_W-1:0] rx_frame,
  input  logic [sawc8_pkg::BYTE_W-1:0]  tx_byte,
  output sawc8_pkg::res_t              res
);
  import sawc8_pkg::*;

  logic               exp_seq_r, exp_seq_nxt;
  logic               tx_seq_r, tx_seq_nxt;
  logic               waiting_r, waiting_nxt;
  logic [FRAME_W-1:0] held_frame_r, held_frame_nxt;

  logic              rx_seq;
  logic [1:0]        rx_type;
  logic [BYTE_W-1:0] rx_pay;
  logic              rx_ok;
  logic              is_start, is_stop, is_ctrl, is_ack;

  // frame fields and checks
  assign rx_seq   = rx_frame[18];
  assign rx_type  = rx_frame[17:16];
  assign rx_pay   = rx_frame[15:8];
  assign rx_ok    = (crc8_frame(rx_frame) == '0);
  assign is_start = (rx_type == TYPE_CMD) && (rx_pay == PAY_START);
  assign is_stop  = (rx_type == TYPE_CMD) && (rx_pay == PAY_STOP);
  assign is_ctrl  = (rx_type == TYPE_CTRL);
  assign is_ack   = rx_ok && (rx_type == TYPE_ACK) && (rx_pay == PAY_ACK)
                    && (rx_seq == ~tx_seq_r);

  // decision for the current word
  always_comb begin
    exp_seq_nxt      = exp_seq_r;
    tx_seq_nxt       = tx_seq_r;
    waiting_nxt      = waiting_r;
    held_frame_nxt   = held_frame_r;
    res.tx_valid     = 1'b0;
    res.tx_frame     = '0;
    res.event_res    = EV_REJECTED;
    res.angle_code   = 2'd3;
    res.sample_count = '0;
    unique case (op)
      OP_RX: begin
        if (waiting_r) begin
          if (is_ack) begin
            tx_seq_nxt    = ~tx_seq_r;
            waiting_nxt   = 1'b0;
            res.event_res = EV_ACKED;
          end else begin
            res.tx_valid  = 1'b1;
            res.tx_frame  = held_frame_r;
            res.event_res = EV_BAD_ACK;
          end
        end else if (rx_ok && (is_start || is_stop || is_ctrl)) begin
          if (rx_seq == exp_seq_r) begin
            exp_seq_nxt = ~exp_seq_r;
            if (is_start) begin
              res.event_res = EV_START;
            end else if (is_stop) begin
              res.event_res = EV_STOP;
            end else begin
              res.event_res    = EV_CONTROL;
              // 01->0, 10->1, 11->2, 00 wraps to 3
              res.angle_code   = rx_pay[7:6] - 2'd1;
              res.sample_count = rx_pay[5:0];
            end
          end else begin
            res.event_res = EV_DUP;
          end
          res.tx_valid = 1'b1;
          res.tx_frame = make_frame({exp_seq_nxt, TYPE_ACK, PAY_ACK});
        end
      end
      OP_SEND: begin
        if (waiting_r) begin
          res.event_res = EV_BUSY;
        end else begin
          held_frame_nxt = make_frame({tx_seq_r, TYPE_DATA, tx_byte});
          waiting_nxt    = 1'b1;
          res.tx_valid   = 1'b1;
          res.tx_frame   = held_frame_nxt;
          res.event_res  = EV_SENT;
        end
      end
      OP_TIMEOUT: begin
        res.event_res = EV_TIMEOUT;
        if (waiting_r) begin
          res.tx_valid = 1'b1;
          res.tx_frame = held_frame_r;
        end
      end
      default: begin
        res.event_res = EV_REJECTED;
      end
    endcase
    res.awaiting_ack = waiting_nxt;
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= 1'b0;
      tx_seq_r  <= 1'b0;
      waiting_r <= 1'b0;
    end else if (accept) begin
      exp_seq_r <= exp_seq_nxt;
      tx_seq_r  <= tx_seq_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  // held frame, the whole data frame with its crc
  always_ff @(posedge clk) begin
    if (accept) begin
      held_frame_r <= held_frame_nxt;
    end
  end

  // an outstanding frame is only dropped on an accepted ack
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && waiting_r) |=> waiting_r || $past(is_ack && op == OP_RX))
    else $error("outstanding frame dropped without an ack");

  // the receive sequence bit only moves on an idle received command or control frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (exp_seq_r != exp_seq_nxt) |-> (op == OP_RX && !waiting_r && rx_ok))
    else $error("receive sequence bit moved on a non-command word");

  // sending while idle always produces a data frame carrying the send bit
  assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SEND && !waiting_r) |->
      (res.tx_valid && res.tx_frame[18] == tx_seq_r && res.tx_frame[17:16] == TYPE_DATA))
    else $error("data frame built with wrong header");

endmodule

### rtl/sawc8_skid.sv
// ----------------------------------------------------------------------------
// sawc8_skid
// Result register with a skid stage, so a new word is taken while the
// previous result is still held on a stalled output.
// ----------------------------------------------------------------------------
module sawc8_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sawc8_pkg::res_t in_res,
  output logic            out_valid,
  input  logic            out_stall,
  output sawc8_pkg::res_t out_res
);
  import sawc8_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic accept;
  logic out_free;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // output and skid slot steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        if (accept) begin
          out_res_nxt = in_res;
        end
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = in_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // skid only holds a word behind a full output slot
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without an output word ahead of it");

  // skid fills only when the output slot is held
  assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && accept && !out_free) |=> skid_valid_r && out_valid_r)
    else $error("word lost behind a stalled output");

  // a freed output slot takes the skid word next
  assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_free) |=> out_valid_r && !skid_valid_r)
    else $error("skid word not moved to output");

endmodule

### rtl/stop_and_wait_crc8_link_endpoint.sv
// ----------------------------------------------------------------------------
// stop_and_wait_crc8_link_endpoint
// Alternating-bit stop-and-wait endpoint with crc-8 protected 19-bit frames.
// ----------------------------------------------------------------------------
// Each input word (received frame, send request or ack timeout) yields exactly
// one result word, registered and shown in the cycle after it is taken unless
// an earlier result is still held by a stalled output; a word can be taken in
// every unstalled cycle. All decoding, crc checking and crc generation happen
// in a single pass between the protocol state and the result register, and a
// two-word output buffer keeps input words flowing while one result waits on
// a stalled output. in_stall rises only when both result slots are full.
module stop_and_wait_crc8_link_endpoint (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [sawc8_pkg::FRAME_W-1:0] in_rx_frame,
  input  logic [sawc8_pkg::BYTE_W-1:0]  in_tx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_tx_valid,
  output logic [sawc8_pkg::FRAME_W-1:0] out_tx_frame,
  output logic [3:0]                    out_event_res,
  output logic [1:0]                    out_angle_code,
  output logic [5:0]                    out_sample_count,
  output logic                          out_awaiting_ack
);
  import sawc8_pkg::*;

  logic accept;
  res_t eng_res;
  res_t out_res;

  assign accept = in_valid && !in_stall;

  // protocol decisions
  sawc8_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_op),
    .rx_frame (in_rx_frame),
    .tx_byte  (in_tx_byte),
    .res      (eng_res)
  );

  // result register and skid stage
  sawc8_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (eng_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_tx_valid     = out_res.tx_valid;
  assign out_tx_frame     = out_res.tx_frame;
  assign out_event_res    = out_res.event_res;
  assign out_angle_code   = out_res.angle_code;
  assign out_sample_count = out_res.sample_count;
  assign out_awaiting_ack = out_res.awaiting_ack;

  // no frame content without a send
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tx_valid) |-> (out_tx_frame == '0))
    else $error("frame bits set on a word with nothing to send");

  // an accepted ack always clears the wait, a sent frame always sets it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_res != EV_ACKED) || !out_awaiting_ack)
                  && ((out_event_res != EV_SENT) || (out_awaiting_ack && out_tx_valid)))
    else $error("wait flag inconsistent with event");

  // busy is only reported while a frame is outstanding
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_BUSY) |-> (out_awaiting_ack && !out_tx_valid))
    else $error("busy reported with no outstanding frame");

endmodule
